// ===== src/chs_pkg.sv =====
// Shared constants and codes of the chained hash set engine.
`timescale 1ns / 1ps

package chs_pkg;

    // Field widths
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 3;

    // Default table geometry
    localparam int BUCKETS_DEF    = 7;
    localparam int POOL_NODES_DEF = 64;

    // Bucket reduction: key bits consumed per cycle, and the number of steps this takes
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = (KEY_W + MOD_DIGIT_W - 1) / MOD_DIGIT_W;
    localparam int MOD_PAD_W   = MOD_STEPS * MOD_DIGIT_W;

    // Operation codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    // Result codes
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

endpackage

// ===== src/chained_hash_set_engine.sv =====
// Top level: hash set with separate chaining over a head RAM and a node pool RAM.
//
//  channel | ports        | dir | contents
//  --------+--------------+-----+------------------------------------------
//  input   | s_t*         | in  | request: tdata value, tuser op
//  result  | m_t*         | out | one status per request
//
// Per request: it is taken, its key is reduced to a bucket, the chain head is read, and
// each node in the chain is read and compared; at the chain end an insert writes a new
// node at the head, unless the pool is full; then the result is handed over.
// After reset the head RAM is cleared one bucket a cycle; s_tready stays low.
// A finished result waits in the output register while the next request runs;
// a second result waits until the first is taken.
`timescale 1ns / 1ps

module chained_hash_set_engine #(
    parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [2:0] status, [7:3] zero
);

    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int PTR_W   = $clog2(POOL_NODES + 1);
    localparam int NODE_AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int KEY_W   = chs_pkg::KEY_W;
    localparam int NODE_W  = KEY_W + PTR_W;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_HASH     = 8'b0000_0100,
        S_HEAD_LAT = 8'b0000_1000,
        S_WALK     = 8'b0001_0000,
        S_NODE_LAT = 8'b0010_0000,
        S_INSERT   = 8'b0100_0000,
        S_RESP     = 8'b1000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [BKT_W-1:0]              clr_reg, clr_next;
    logic [PTR_W-1:0]              used_reg, used_next;
    logic                          op_reg, op_next;
    logic [KEY_W-1:0]              key_reg, key_next;
    logic [BKT_W-1:0]              bucket_reg, bucket_next;
    logic [PTR_W-1:0]              head_reg, head_next;
    logic [PTR_W-1:0]              ptr_reg, ptr_next;
    logic [chs_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic                          m_valid_reg, m_valid_next;
    logic [chs_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;

    logic                          mod_start, mod_done;
    logic [BKT_W-1:0]              mod_bucket;

    logic                          head_we, head_re;
    logic [BKT_W-1:0]              head_waddr, head_raddr;
    logic [PTR_W-1:0]              head_wdata, head_rdata;

    logic                          node_we, node_re;
    logic [NODE_AW-1:0]            node_waddr, node_raddr;
    logic [NODE_W-1:0]             node_wdata, node_rdata;
    logic [PTR_W-1:0]              ptr_dec;

    logic                          accept;
    logic                          out_free;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign ptr_dec  = ptr_reg - PTR_W'(1);

    // Bucket reduction unit
    chs_bucket_mod #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .key     (s_tdata[KEY_W-1:0]),
        .done    (mod_done),
        .bucket  (mod_bucket)
    );

    // Chain heads, node number + 1, zero for an empty chain
    chs_ram #(
        .WIDTH (PTR_W),
        .DEPTH (BUCKETS)
    ) u_heads (
        .aclk  (aclk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    // Node pool: {link, key}
    chs_ram #(
        .WIDTH (NODE_W),
        .DEPTH (POOL_NODES)
    ) u_nodes (
        .aclk  (aclk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Memory port drive
    always_comb begin
        head_we    = (state_reg == S_CLEAR) || (state_reg == S_INSERT);
        head_waddr = (state_reg == S_CLEAR) ? clr_reg : bucket_reg;
        head_wdata = (state_reg == S_CLEAR) ? '0 : used_reg + PTR_W'(1);
        head_re    = (state_reg == S_HASH) && mod_done;
        head_raddr = mod_bucket;

        node_we    = (state_reg == S_INSERT);
        node_waddr = used_reg[NODE_AW-1:0];
        node_wdata = {head_reg, key_reg};
        node_re    = (state_reg == S_WALK) && (ptr_reg != '0);
        node_raddr = ptr_dec[NODE_AW-1:0];
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign mod_start = accept;

    // Request sequencer
    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        used_next     = used_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        bucket_next   = bucket_reg;
        head_next     = head_reg;
        ptr_next      = ptr_reg;
        status_next   = status_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;

        unique case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BKT_W'(BUCKETS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    op_next    = s_tuser[0];
                    key_next   = s_tdata[KEY_W-1:0];
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    bucket_next = mod_bucket;
                    state_next  = S_HEAD_LAT;
                end
            end
            S_HEAD_LAT: begin
                head_next  = head_rdata;
                ptr_next   = head_rdata;
                state_next = S_WALK;
            end
            S_WALK: begin
                if (ptr_reg != '0) begin
                    state_next = S_NODE_LAT;
                end else if (op_reg == chs_pkg::OP_SEARCH) begin
                    status_next = chs_pkg::ST_NOT_FOUND;
                    state_next  = S_RESP;
                end else if (used_reg == PTR_W'(POOL_NODES)) begin
                    status_next = chs_pkg::ST_POOL_FULL;
                    state_next  = S_RESP;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_NODE_LAT: begin
                if (node_rdata[KEY_W-1:0] == key_reg) begin
                    status_next = (op_reg == chs_pkg::OP_SEARCH) ? chs_pkg::ST_FOUND
                                                                 : chs_pkg::ST_DUPLICATE;
                    state_next  = S_RESP;
                end else begin
                    ptr_next   = node_rdata[NODE_W-1:KEY_W];
                    state_next = S_WALK;
                end
            end
            S_INSERT: begin
                used_next   = used_reg + PTR_W'(1);
                status_next = chs_pkg::ST_INSERTED;
                state_next  = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
        op_reg       <= op_next;
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        head_reg     <= head_next;
        ptr_reg      <= ptr_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = 8'(m_status_reg);

    // Pool count never runs past the pool size
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= PTR_W'(POOL_NODES))
        else $error("node count exceeds pool size");

    // An insert write hands out exactly one node
    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INSERT) |=> (used_reg == $past(used_reg) + PTR_W'(1)))
        else $error("insert did not advance node count");

    // Pool full is reported only with the pool exhausted
    a_full_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESP && status_reg == chs_pkg::ST_POOL_FULL)
        |-> (used_reg == PTR_W'(POOL_NODES)))
        else $error("pool full reported with free nodes");

    // No request is taken during the head clearing pass
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> !s_tready)
        else $error("request taken while clearing heads");

    // A node read is only issued for a live pointer
    a_node_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        node_re |-> (ptr_reg <= used_reg))
        else $error("chain pointer beyond handed-out nodes");

endmodule

// ===== src/chs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module chs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/chs_bucket_mod.sv =====
// Key modulo bucket count, reduced a few key bits per cycle.
`timescale 1ns / 1ps

module chs_bucket_mod #(
    parameter int BUCKETS = chs_pkg::BUCKETS_DEF,
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int REM_W = $clog2(BUCKETS) + 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [chs_pkg::KEY_W-1:0] key,
    output logic                     done,
    output logic [BKT_W-1:0]         bucket
);

    localparam int CNT_W = (chs_pkg::MOD_STEPS > 1) ? $clog2(chs_pkg::MOD_STEPS) : 1;

    logic [chs_pkg::MOD_PAD_W-1:0] shift_reg, shift_next;
    logic [REM_W-1:0]              rem_reg, rem_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [REM_W-1:0]              rem_step;

    // One digit of restoring reduction: shift in a bit, subtract once if at or over
    always_comb begin
        logic [REM_W:0] t;
        rem_step = rem_reg;
        for (int i = 0; i < chs_pkg::MOD_DIGIT_W; i++) begin
            t = {rem_step, shift_reg[chs_pkg::MOD_PAD_W-1-i]};
            if (t >= (REM_W+1)'(BUCKETS)) begin
                t = t - (REM_W+1)'(BUCKETS);
            end
            rem_step = t[REM_W-1:0];
        end
    end

    // Sequencing of the reduction
    always_comb begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start) begin
            shift_next = chs_pkg::MOD_PAD_W'(key);
            rem_next   = '0;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            shift_next = shift_reg << chs_pkg::MOD_DIGIT_W;
            rem_next   = rem_step;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(chs_pkg::MOD_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg[BKT_W-1:0];

endmodule
